/* src/address_journal_balance_scan_macros.svh */
// assertion macros for the journal balance scan block
// used by the top level; expects clk and rst in scope
`ifndef ADDRESS_JOURNAL_BALANCE_SCAN_MACROS_SVH
`define ADDRESS_JOURNAL_BALANCE_SCAN_MACROS_SVH

// same-cycle implication
`define AJBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AJBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ajbs_pkg.sv */
// shared types and codes for the journal balance scan block
// no dependencies
package ajbs_pkg;

  // record function codes
  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_SPEND  = 2'd1;
  localparam logic [1:0] FN_TOUCH  = 2'd2;
  localparam logic [1:0] FN_FINISH = 2'd3;

  // result kinds
  localparam logic KIND_TXID    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_KEY_TYPE   = 3'd0;
  localparam logic [2:0] REG_KEY_WORD0  = 3'd1;
  localparam logic [2:0] REG_KEY_WORD1  = 3'd2;
  localparam logic [2:0] REG_KEY_WORD2  = 3'd3;
  localparam logic [2:0] REG_KEY_WORD3  = 3'd4;
  localparam logic [2:0] REG_TXID_LIMIT = 3'd5;

  localparam logic [8:0] TXID_LIMIT_RST = 9'd256;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rec_type;
    logic [63:0] hash_w0;
    logic [63:0] hash_w1;
    logic [63:0] hash_w2;
    logic [63:0] hash_w3;
    logic [63:0] tx_w0;
    logic [63:0] tx_w1;
    logic [63:0] tx_w2;
    logic [63:0] tx_w3;
    logic [31:0] out_index;
    logic [63:0] amount;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] txid_out_w0;
    logic [63:0] txid_out_w1;
    logic [63:0] txid_out_w2;
    logic [63:0] txid_out_w3;
    logic [63:0] balance;
    logic [63:0] total_received;
    logic [8:0]  live_output_count;
    logic [8:0]  txid_count;
  } out_t;

  // scan token travelling down a chain of cells
  typedef struct packed {
    logic active;
    logic found;
  } chain_ctrl_t;

endpackage

/* src/address_journal_balance_scan.sv */
// top level of the journal balance scan block: register port, control
// and two chains of ajbs_cell; uses ajbs_pkg and the macros header
//
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall  | ajbs_pkg::in_t
// out     | out       | out_valid/out_stall| ajbs_pkg::out_t
// cfg     | in        | psel/penable/pready| paddr, pwdata, prdata
//
// a matching create/touch sends the scan token down the seen id chain and emits
// the id when it is new and there is room; a matching spend sends it down the live
// chain, one entry a cycle. finish emits the summary; a non-matching record is ignored.
// a waiting result is held in ST_OUT while out_stall is high.
// rst is synchronous and clears counts, sums and control; entries are not cleared.
// in_stall is high while an item is in flight or its result waits on out_stall.
`include "address_journal_balance_scan_macros.svh"
module address_journal_balance_scan #(
  parameter int LIVE_DEPTH = 256,
  parameter int TXID_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ajbs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ajbs_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);
  import ajbs_pkg::*;

  localparam int LIW = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
  localparam int LCW = $clog2(LIVE_DEPTH + 1);
  localparam int SIW = (TXID_DEPTH > 1) ? $clog2(TXID_DEPTH) : 1;
  localparam int SCW = $clog2(TXID_DEPTH + 1);
  localparam int LKW = 288;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t         state;
  logic [7:0]     key_type;
  logic [63:0]    key_word [4];
  logic [8:0]     txid_limit;
  logic           op_spend;
  logic [255:0]   rec_tx;
  logic [31:0]    rec_vout;
  logic           start_live;
  logic           start_seen;
  logic [LCW-1:0] live_cnt;
  logic [SCW-1:0] seen_cnt;
  logic [63:0]    recv;
  logic [63:0]    bal;

  logic           accept;
  logic           key_match;
  logic           live_room;
  logic           seen_room;
  logic [31:0]    eff_limit;
  logic           live_done;
  logic           seen_done;

  chain_ctrl_t    lc [LIVE_DEPTH+1];
  logic [LIW-1:0] li [LIVE_DEPTH+1];
  logic [LKW-1:0] lk [LIVE_DEPTH+1];
  logic [63:0]    lp [LIVE_DEPTH+1];
  logic [63:0]    lh [LIVE_DEPTH+1];
  chain_ctrl_t    sc [TXID_DEPTH+1];
  logic [SIW-1:0] si [TXID_DEPTH+1];
  logic [255:0]   sk [TXID_DEPTH+1];
  logic [0:0]     sp [TXID_DEPTH+1];
  logic [0:0]     sh [TXID_DEPTH+1];

  logic           lwr_en;
  logic [LIW-1:0] lwr_idx;
  logic [LKW-1:0] lwr_key;
  logic [63:0]    lwr_pay;
  logic           swr_en;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_type    <= '0;
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
      txid_limit  <= TXID_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_KEY_TYPE:   key_type    <= pwdata[7:0];
        REG_KEY_WORD0:  key_word[0] <= pwdata;
        REG_KEY_WORD1:  key_word[1] <= pwdata;
        REG_KEY_WORD2:  key_word[2] <= pwdata;
        REG_KEY_WORD3:  key_word[3] <= pwdata;
        REG_TXID_LIMIT: txid_limit  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_KEY_TYPE:   prdata = {56'd0, key_type};
      REG_KEY_WORD0:  prdata = key_word[0];
      REG_KEY_WORD1:  prdata = key_word[1];
      REG_KEY_WORD2:  prdata = key_word[2];
      REG_KEY_WORD3:  prdata = key_word[3];
      REG_TXID_LIMIT: prdata = {55'd0, txid_limit};
      default:        prdata = '0;
    endcase
  end

  // handshake and record checks
  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_valid = state == ST_OUT;
  assign key_match = (in_data.rec_type == key_type) && (in_data.hash_w0 == key_word[0]) &&
                     (in_data.hash_w1 == key_word[1]) && (in_data.hash_w2 == key_word[2]) &&
                     (in_data.hash_w3 == key_word[3]);
  assign live_room = live_cnt < LCW'(LIVE_DEPTH);
  assign eff_limit = (32'(txid_limit) < 32'(TXID_DEPTH)) ? 32'(txid_limit) : 32'(TXID_DEPTH);
  assign seen_room = 32'(seen_cnt) < eff_limit;
  assign live_done = lc[LIVE_DEPTH].active;
  assign seen_done = sc[TXID_DEPTH].active;

  // live table writes: append on create, fill the hole on spend
  always_comb begin
    lwr_en  = 1'b0;
    lwr_idx = live_cnt[LIW-1:0];
    lwr_key = {in_data.tx_w3, in_data.tx_w2, in_data.tx_w1, in_data.tx_w0,
               in_data.out_index};
    lwr_pay = in_data.amount;
    priority if (accept && key_match && (in_data.func == FN_CREATE) && live_room) begin
      lwr_en = 1'b1;
    end else if (state == ST_SCAN && op_spend && live_done && lc[LIVE_DEPTH].found) begin
      lwr_en  = 1'b1;
      lwr_idx = li[LIVE_DEPTH];
      lwr_key = lk[LIVE_DEPTH];
      lwr_pay = lp[LIVE_DEPTH];
    end
  end

  assign swr_en = (state == ST_SCAN) && !op_spend && seen_done &&
                  !sc[TXID_DEPTH].found && seen_room;

  // chain heads
  assign lc[0] = '{active: start_live, found: 1'b0};
  assign li[0] = '0;
  assign lk[0] = '0;
  assign lp[0] = '0;
  assign lh[0] = '0;
  assign sc[0] = '{active: start_seen, found: 1'b0};
  assign si[0] = '0;
  assign sk[0] = '0;
  assign sp[0] = '0;
  assign sh[0] = '0;

  // live output chain
  for (genvar g = 0; g < LIVE_DEPTH; g++) begin : g_live
    ajbs_cell #(
      .KEY_W(LKW), .PAY_W(64), .IDX_W(LIW), .CNT_W(LCW), .INDEX(g)
    ) u_cell (
      .clk(clk), .rst(rst), .cnt(live_cnt), .qkey({rec_tx, rec_vout}),
      .wr_en(lwr_en), .wr_idx(lwr_idx), .wr_key(lwr_key), .wr_pay(lwr_pay),
      .ci(lc[g]), .ci_idx(li[g]), .ci_lkey(lk[g]), .ci_lpay(lp[g]), .ci_hpay(lh[g]),
      .co(lc[g+1]), .co_idx(li[g+1]), .co_lkey(lk[g+1]), .co_lpay(lp[g+1]),
      .co_hpay(lh[g+1])
    );
  end

  // seen id chain
  for (genvar g = 0; g < TXID_DEPTH; g++) begin : g_seen
    ajbs_cell #(
      .KEY_W(256), .PAY_W(1), .IDX_W(SIW), .CNT_W(SCW), .INDEX(g)
    ) u_cell (
      .clk(clk), .rst(rst), .cnt(seen_cnt), .qkey(rec_tx),
      .wr_en(swr_en), .wr_idx(seen_cnt[SIW-1:0]), .wr_key(rec_tx), .wr_pay(1'b0),
      .ci(sc[g]), .ci_idx(si[g]), .ci_lkey(sk[g]), .ci_lpay(sp[g]), .ci_hpay(sh[g]),
      .co(sc[g+1]), .co_idx(si[g+1]), .co_lkey(sk[g+1]), .co_lpay(sp[g+1]),
      .co_hpay(sh[g+1])
    );
  end

  // control, counters and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      start_live <= 1'b0;
      start_seen <= 1'b0;
      live_cnt   <= '0;
      seen_cnt   <= '0;
      recv       <= '0;
      bal        <= '0;
    end else begin
      start_live <= 1'b0;
      start_seen <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.func == FN_FINISH) begin
              live_cnt <= '0;
              seen_cnt <= '0;
              recv     <= '0;
              bal      <= '0;
              state    <= ST_OUT;
            end else if (key_match) begin
              if (in_data.func == FN_CREATE) begin
                if (live_room) begin
                  live_cnt <= live_cnt + LCW'(1);
                  bal      <= bal + in_data.amount;
                end
                recv <= recv + in_data.amount;
              end
              if (in_data.func == FN_SPEND) begin
                start_live <= 1'b1;
              end else begin
                start_seen <= 1'b1;
              end
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (op_spend && live_done) begin
            if (lc[LIVE_DEPTH].found) begin
              bal      <= bal - lh[LIVE_DEPTH];
              live_cnt <= live_cnt - LCW'(1);
            end
            state <= ST_IDLE;
          end else if (!op_spend && seen_done) begin
            if (swr_en) begin
              seen_cnt <= seen_cnt + SCW'(1);
              state    <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // record hold and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_spend <= in_data.func == FN_SPEND;
      rec_tx   <= {in_data.tx_w3, in_data.tx_w2, in_data.tx_w1, in_data.tx_w0};
      rec_vout <= in_data.out_index;
    end
    if (accept && in_data.func == FN_FINISH) begin
      out_data <= '{result_kind: KIND_SUMMARY,
                    txid_out_w0: 64'd0, txid_out_w1: 64'd0,
                    txid_out_w2: 64'd0, txid_out_w3: 64'd0,
                    balance: bal, total_received: recv,
                    live_output_count: 9'(32'(live_cnt)),
                    txid_count: 9'(32'(seen_cnt))};
    end else if (swr_en) begin
      out_data <= '{result_kind: KIND_TXID,
                    txid_out_w0: rec_tx[63:0], txid_out_w1: rec_tx[127:64],
                    txid_out_w2: rec_tx[191:128], txid_out_w3: rec_tx[255:192],
                    balance: 64'd0, total_received: 64'd0,
                    live_output_count: 9'd0, txid_count: 9'd0};
    end
  end

  // checks
  `AJBS_ASSERT_NOW(a_live_bound, 1'b1, live_cnt <= LCW'(LIVE_DEPTH), "live count over depth")
  `AJBS_ASSERT_NOW(a_seen_bound, 1'b1, seen_cnt <= SCW'(TXID_DEPTH), "seen count over depth")
  `AJBS_ASSERT_NOW(a_done_in_scan, live_done || seen_done, state == ST_SCAN, "scan end outside scan")
  `AJBS_ASSERT_NEXT(a_id_result, swr_en, out_valid && out_data.result_kind == KIND_TXID, "id not shown")

endmodule

/* src/ajbs_cell.sv */
// one table entry of a search chain: holds a key and payload, compares
// against the broadcast query as the scan token passes; uses ajbs_pkg
module ajbs_cell #(
  parameter int KEY_W = 288,
  parameter int PAY_W = 64,
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_W-1:0]     cnt,
  input  logic [KEY_W-1:0]     qkey,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [KEY_W-1:0]     wr_key,
  input  logic [PAY_W-1:0]     wr_pay,
  input  ajbs_pkg::chain_ctrl_t ci,
  input  logic [IDX_W-1:0]     ci_idx,
  input  logic [KEY_W-1:0]     ci_lkey,
  input  logic [PAY_W-1:0]     ci_lpay,
  input  logic [PAY_W-1:0]     ci_hpay,
  output ajbs_pkg::chain_ctrl_t co,
  output logic [IDX_W-1:0]     co_idx,
  output logic [KEY_W-1:0]     co_lkey,
  output logic [PAY_W-1:0]     co_lpay,
  output logic [PAY_W-1:0]     co_hpay
);
  import ajbs_pkg::*;

  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] pay;
  logic             own_valid;
  logic             is_last;
  logic             hit;

  // entry occupancy and match
  assign own_valid = CNT_W'(INDEX) < cnt;
  assign is_last   = CNT_W'(INDEX + 1) == cnt;
  assign hit       = ci.active && !ci.found && own_valid && (key == qkey);

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
      key <= wr_key;
      pay <= wr_pay;
    end
  end

  // token hop and carried payload
  always_ff @(posedge clk) begin
    if (rst) begin
      co.active <= 1'b0;
    end else begin
      co.active <= ci.active;
    end
    co.found <= ci.found || hit;
    co_idx   <= hit ? IDX_W'(INDEX) : ci_idx;
    co_hpay  <= hit ? pay : ci_hpay;
    co_lkey  <= (ci.active && is_last) ? key : ci_lkey;
    co_lpay  <= (ci.active && is_last) ? pay : ci_lpay;
  end

endmodule
